// ----- hdl/pdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_pkg
// Types and constants shared by the phase-angle dimmer timer modules.
// ----------------------------------------------------------------------------
package pdt_pkg;

   // Command codes carried on the request tuser field
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_ZERO  = 2'd1,
      CMD_LEVEL = 2'd2
   } cmd_type;

   localparam int unsigned CMD_W     = 2;
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned PERIOD_W  = 16;
   localparam int unsigned ANGLE_W   = 8;
   localparam int unsigned DEGREE_W  = 8;
   localparam int unsigned RSP_W     = 40;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd60000;
   localparam logic [ANGLE_W-1:0]  ANGLE_START  = 8'd255;
   localparam logic [LEVEL_W-1:0]  LEVEL_RESET  = 8'd255;

   // One request word as held in the input register
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [LEVEL_W-1:0] level;
   } item_type;

   // One result word
   typedef struct packed {
      logic [DEGREE_W-1:0] degree_length;
      logic [PERIOD_W-1:0] period_estimate;
      logic [ANGLE_W-1:0]  firing_angle;
      logic                gate_on;
   } result_type;

endpackage : pdt_pkg
`default_nettype wire

// ----- hdl/pdt_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_in_stage
// Input register: captures one request word per cycle unless stalled and hands
// it to the timer core as soon as the core can take it.
// ----------------------------------------------------------------------------
module pdt_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pdt_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pdt_pkg::item_type      out_item
);
   import pdt_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Take a new word whenever the held one leaves or none is held
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload; no reset needed
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule : pdt_in_stage
`default_nettype wire

// ----- hdl/pdt_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pdt_core
// Timer state and result register: applies one tick, zero crossing or level
// word per cycle unless stalled; registers the gate, angle and period figures.
// ----------------------------------------------------------------------------
module pdt_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire pdt_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pdt_pkg::result_type    out_result
);
   import pdt_pkg::*;

   logic [PERIOD_W-1:0] period_counter_ff, period_counter_in;
   logic [PERIOD_W-1:0] period_estimate_ff, period_estimate_in;
   logic [DEGREE_W-1:0] degree_counter_ff, degree_counter_in;
   logic [ANGLE_W-1:0]  angle_count_ff, angle_count_in;
   logic [LEVEL_W-1:0]  dim_level_ff, dim_level_in;
   logic                gate_ff, gate_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          result_ff;
   logic [DEGREE_W-1:0] degree_length;
   logic                fire;
   cmd_type             cmd;

   // Step length is always the top byte of the estimate
   assign degree_length = period_estimate_ff[PERIOD_W-1 -: DEGREE_W];

   assign in_ready = !rsp_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;
   assign cmd      = cmd_type'(in_item.cmd);

   // Next timer state for the word in the input register
   always_comb begin
      period_counter_in  = period_counter_ff;
      period_estimate_in = period_estimate_ff;
      degree_counter_in  = degree_counter_ff;
      angle_count_in     = angle_count_ff;
      dim_level_in       = dim_level_ff;
      gate_in            = gate_ff;
      case (cmd)
         CMD_TICK: begin
            period_counter_in = period_counter_ff + 1'b1;
            if (degree_counter_ff == degree_length) begin
               if (dim_level_ff >= angle_count_ff) begin
                  gate_in = 1'b1;
               end
               if (angle_count_ff > 8'd1) begin
                  angle_count_in = angle_count_ff - 1'b1;
               end
               degree_counter_in = '0;
            end else begin
               degree_counter_in = degree_counter_ff + 1'b1;
            end
         end
         CMD_ZERO: begin
            gate_in        = 1'b0;
            angle_count_in = ANGLE_START;
            if (period_estimate_ff > period_counter_ff) begin
               period_estimate_in = period_estimate_ff - 1'b1;
            end else if (period_estimate_ff < period_counter_ff) begin
               period_estimate_in = period_estimate_ff + 1'b1;
            end
            period_counter_in = '0;
            degree_counter_in = '0;
         end
         CMD_LEVEL: begin
            dim_level_in = in_item.level;
         end
         default: begin
            // unused code: state holds
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (in_ready) begin
         rsp_valid_in = in_valid;
      end
   end

   // Advance the state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         period_counter_ff  <= '0;
         period_estimate_ff <= PERIOD_RESET;
         degree_counter_ff  <= '0;
         angle_count_ff     <= ANGLE_START;
         dim_level_ff       <= LEVEL_RESET;
         gate_ff            <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            period_counter_ff  <= period_counter_in;
            period_estimate_ff <= period_estimate_in;
            degree_counter_ff  <= degree_counter_in;
            angle_count_ff     <= angle_count_in;
            dim_level_ff       <= dim_level_in;
            gate_ff            <= gate_in;
         end
      end
   end

   // Register the result word
   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff.gate_on         <= gate_in;
         result_ff.firing_angle    <= angle_count_in;
         result_ff.period_estimate <= period_estimate_in;
         result_ff.degree_length   <= period_estimate_in[PERIOD_W-1 -: DEGREE_W];
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_result = result_ff;

   // Step counter never passes the step length
   a_degree_bound : assert property (@(posedge clock) disable iff (reset)
      degree_counter_ff <= degree_length)
      else $error("degree counter beyond step length");

   // Angle count never reaches zero
   a_angle_nonzero : assert property (@(posedge clock) disable iff (reset)
      angle_count_ff != '0)
      else $error("angle count reached zero");

   // A zero crossing leaves the gate off and the angle restarted
   a_zero_clears : assert property (@(posedge clock) disable iff (reset)
      fire && (in_item.cmd == CMD_ZERO) |=>
         !gate_ff && (angle_count_ff == ANGLE_START) && (degree_counter_ff == '0))
      else $error("zero crossing did not restart the half cycle");

   // Result gate matches the live gate after each accepted word
   a_result_gate : assert property (@(posedge clock) disable iff (reset)
      fire |=> (result_ff.gate_on == gate_ff))
      else $error("result gate differs from state");

endmodule : pdt_core
`default_nettype wire

// ----- hdl/phase_angle_dimmer_timer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phase_angle_dimmer_timer_top
// Phase-control dimmer timer for one mains channel: ticks, zero crossings and
// level words drive a triac gate through a backward-running angle count.
//
//  Channel | Direction | Handshake            | Payload
//  req_    | in        | req_tvalid/tready    | tuser = cmd, tdata = level
//  rsp_    | out       | rsp_tvalid/tready    | tdata = gate, angle, estimate, step
//
// One word per cycle sustained while the result side takes results; each word
// passes through the input register and then the result register of the timer
// core before its result is shown. Reset (synchronous, active high) sets the
// estimate to 60000, the level and angle to 255 and clears the gate and counters.
// A stalled result holds; the input register keeps taking words while the
// core and result register have room.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_timer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] level
   input  wire logic [1:0]  req_tuser,   // [1:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [0] gate_on, [8:1] firing_angle,
                                         // [24:9] period_estimate_out,
                                         // [32:25] degree_length_out, [39:33] zero
);
   import pdt_pkg::*;

   item_type   req_item;
   item_type   core_item;
   logic       core_valid;
   logic       core_ready;
   result_type rsp_result;

   assign req_item.cmd   = req_tuser;
   assign req_item.level = req_tdata;

   pdt_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_item  (core_item)
   );

   pdt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (core_valid),
      .in_ready   (core_ready),
      .in_item    (core_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   // Pack the result word, padded to whole bytes
   assign rsp_tdata = {{(RSP_W - $bits(result_type)){1'b0}}, rsp_result};

endmodule : phase_angle_dimmer_timer_top
`default_nettype wire

// ----- sim/phase_angle_dimmer_timer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_angle_dimmer_timer_top_test
// Self-checking bench for the phase-angle dimmer timer. Tick, zero-crossing
// and level words go in on the request stream. A model of the timer inside
// the bench predicts the gate, angle, estimate and step length for every
// word. Each result word is checked against the oldest prediction. Directed
// tests cover the command codes, the first angle step with full and zero
// levels, and a stretch at full rate on both sides. Random half cycles with
// level changes and noise words run around them.
// ----------------------------------------------------------------------------
module phase_angle_dimmer_timer_top_test;
   import pdt_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
   localparam int unsigned      IDLE_PERCENT   = 28;
   localparam int unsigned      WATCHDOG_LIMIT = 2000;
   localparam int unsigned      DRAIN_CYCLES   = 10;
   localparam int unsigned      MAX_REPORTS    = 100;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [LEVEL_W-1:0]  req_tdata  = '0;   // [7:0] level
   logic [CMD_W-1:0]    req_tuser  = '0;   // [1:0] cmd
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;         // [0] gate_on, [8:1] firing_angle,
                                           // [24:9] period_estimate_out,
                                           // [32:25] degree_length_out, [39:33] zero

   // Timer model state
   logic [PERIOD_W-1:0] ticks_since_zero;
   logic [PERIOD_W-1:0] period_est;
   logic [DEGREE_W-1:0] ticks_per_step;
   logic [DEGREE_W-1:0] step_ticks;
   logic [ANGLE_W-1:0]  back_angle;
   logic [LEVEL_W-1:0]  dim_level;
   logic                gate_q;

   result_type          expected_results[$];
   int unsigned         mismatch_count = 0;
   int unsigned         words_sent     = 0;
   int unsigned         idle_cycles    = 0;
   bit                  no_idle        = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   phase_angle_dimmer_timer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function void reset_timer_model();
      ticks_since_zero = '0;
      period_est       = PERIOD_RESET;
      ticks_per_step   = PERIOD_RESET[15:8];
      step_ticks       = '0;
      back_angle       = ANGLE_START;
      dim_level        = LEVEL_RESET;
      gate_q           = 1'b0;
   endfunction

   // Advance the model by one word and queue the result it should show
   function void advance_timer(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] level);
      result_type predicted;
      case (cmd)
         CMD_TICK: begin
            ticks_since_zero = ticks_since_zero + 1'b1;
            if (step_ticks == ticks_per_step) begin
               if (dim_level >= back_angle)
                  gate_q = 1'b1;
               if (back_angle > 8'd1)
                  back_angle = back_angle - 1'b1;
               step_ticks = '0;
            end else begin
               step_ticks = step_ticks + 1'b1;
            end
         end
         CMD_ZERO: begin
            gate_q     = 1'b0;
            back_angle = ANGLE_START;
            // nudge the estimate one count toward the measured half cycle
            if (period_est > ticks_since_zero)
               period_est = period_est - 1'b1;
            else if (period_est < ticks_since_zero)
               period_est = period_est + 1'b1;
            ticks_per_step   = period_est[15:8];
            ticks_since_zero = '0;
            step_ticks       = '0;
         end
         CMD_LEVEL: begin
            dim_level = level;
         end
         default: begin
         end
      endcase
      predicted.gate_on         = gate_q;
      predicted.firing_angle    = back_angle;
      predicted.period_estimate = period_est;
      predicted.degree_length   = ticks_per_step;
      expected_results.push_back(predicted);
   endfunction

   // Pick a level at, just under, or anywhere around the current angle
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(3))
         0:       return back_angle;
         1:       return back_angle - 1'b1;
         default: return LEVEL_W'($urandom_range(255));
      endcase
   endfunction

   function void check_field(input string name, input logic [PERIOD_W-1:0] want,
                             input logic [PERIOD_W-1:0] seen);
      if (want !== seen) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      end
   endfunction

   // Send one request word, with a random gap before it
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] level);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= level;
      do @(posedge clock); while (!req_tready);
      advance_timer(cmd, level);
      words_sent++;
   endtask

   task automatic send_ticks(input int unsigned count);
      repeat (count) send_word(CMD_TICK, LEVEL_W'($urandom_range(255)));
   endtask

   // Hold off the sender until every predicted word has come back
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_commands();
      // unused command with both extremes of the ignored level field
      send_word(CMD_UNUSED, 8'hFF);
      send_word(CMD_UNUSED, 8'h00);
      send_word(CMD_LEVEL, 8'h00);
      send_word(CMD_TICK, 8'hFF);
      send_word(CMD_LEVEL, 8'hFF);
      send_word(CMD_TICK, 8'h00);
      send_word(CMD_ZERO, 8'hA5);
      send_word(CMD_ZERO, 8'h5A);
      send_word(CMD_LEVEL, 8'hAA);
      send_word(CMD_LEVEL, 8'h55);
      send_word(CMD_TICK, 8'h5A);
      send_word(CMD_UNUSED, 8'h3C);
      send_word(CMD_LEVEL, LEVEL_RESET);
      wait_results_drained();
   endtask

   task automatic test_first_step();
      // full level fires on the first step and stays latched after a drop
      send_word(CMD_ZERO, 8'h00);
      send_word(CMD_LEVEL, 8'hFF);
      send_ticks(int'(ticks_per_step) + 1);
      send_word(CMD_LEVEL, 8'h00);
      send_ticks(int'(ticks_per_step) + 2);
      send_word(CMD_ZERO, 8'hFF);
      // zero level never fires
      send_ticks(int'(ticks_per_step) + 1);
      send_word(CMD_ZERO, 8'h00);
      wait_results_drained();
   endtask

   task automatic test_random_traffic(input int unsigned count);
      int unsigned stop_at;
      int unsigned span;
      int unsigned choice;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         choice = $urandom_range(99);
         if (choice < 75) begin
            // well-formed half cycle with level changes sprinkled in
            choice = $urandom_range(99);
            if (choice < 30)
               span = $urandom_range(8);
            else if (choice < 80)
               span = $urandom_range(3 * (int'(ticks_per_step) + 1) + 8);
            else if (period_est < 16'd2048)
               span = int'(period_est) + $urandom_range(4) - 2;
            else
               span = $urandom_range(600);
            // keep the run close to the requested word count
            if (words_sent + span + 1 > stop_at)
               span = stop_at - words_sent - 1;
            repeat (span) begin
               choice = $urandom_range(99);
               if (choice < 4)
                  send_word(CMD_LEVEL, pick_level());
               else if (choice < 5)
                  send_word(CMD_UNUSED, LEVEL_W'($urandom_range(255)));
               else
                  send_word(CMD_TICK, LEVEL_W'($urandom_range(255)));
            end
            send_word(CMD_ZERO, LEVEL_W'($urandom_range(255)));
         end else begin
            // noise: any command with any level
            repeat ($urandom_range(6, 1))
               send_word(CMD_W'($urandom_range(3)), pick_level());
         end
      end
      wait_results_drained();
   endtask

   task automatic test_full_rate_burst(input int unsigned count);
      // both sides stay ready throughout, so words go back to back
      no_idle = 1'b1;
      test_random_traffic(count);
      no_idle = 1'b0;
   endtask

   // Check each result word, drive the result ready and count idle cycles
   always @(posedge clock) begin : check_results
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[$bits(result_type)-1:0];
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result expected none, got %h", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            check_field("gate_on", PERIOD_W'(want.gate_on), PERIOD_W'(seen.gate_on));
            check_field("firing_angle", PERIOD_W'(want.firing_angle),
                        PERIOD_W'(seen.firing_angle));
            check_field("period_estimate", want.period_estimate, seen.period_estimate);
            check_field("degree_length", PERIOD_W'(want.degree_length),
                        PERIOD_W'(seen.degree_length));
            check_field("padding", '0, PERIOD_W'(rsp_tdata[RSP_W-1:$bits(result_type)]));
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Stop a run that has stalled
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset_timer_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_commands();
      test_first_step();
      test_random_traffic(300);
      test_full_rate_burst(300);
      test_random_traffic(326);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
